// ===== sv/bei_pkg.sv =====
package bei_pkg;

    localparam int SIZE_BITS     = 16;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_SLOTS     = 4;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_OUT_SIZE_BASE = 4'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_IN_SIZE_BASE  = 4'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_END           = 4'd8;

    typedef logic [SIZE_BITS-1:0] size_t;

    typedef struct packed {
        size_t out_size;
        size_t in_size;
    } dim_cfg_t;

    function automatic size_t dim_or_one(size_t v);
        dim_or_one = (v == '0) ? size_t'(1) : v;
    endfunction

endpackage

// ===== sv/bei_dim.sv =====
module bei_dim #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bei_pkg::dim_cfg_t cfg,
    input  logic             in_valid,
    input  logic [W-1:0]     in_rem,
    input  logic [W-1:0]     in_src,
    input  logic [W-1:0]     in_stride,
    output logic             out_valid,
    output logic [W-1:0]     out_rem,
    output logic [W-1:0]     out_src,
    output logic [W-1:0]     out_stride
);
    import bei_pkg::*;

    size_t od;
    size_t id;
    assign od = dim_or_one(cfg.out_size);
    assign id = dim_or_one(cfg.in_size);

    // one restoring division step per stage; q shifts dividend out, quotient in
    logic             v_reg      [0:W-1];
    logic [W-1:0]     q_reg      [0:W-1];
    size_t            r_reg      [0:W-1];
    logic [W-1:0]     src_reg    [0:W-1];
    logic [W-1:0]     stride_reg [0:W-1];

    for (genvar s = 0; s < W; s++) begin : g_step
        logic             v_prev;
        logic [W-1:0]     q_prev;
        size_t            r_prev;
        logic [W-1:0]     src_prev;
        logic [W-1:0]     stride_prev;
        logic [SIZE_BITS:0] t_next;
        logic             ge_next;

        if (s == 0) begin : g_first
            assign v_prev      = in_valid;
            assign q_prev      = in_rem;
            assign r_prev      = '0;
            assign src_prev    = in_src;
            assign stride_prev = in_stride;
        end else begin : g_rest
            assign v_prev      = v_reg[s-1];
            assign q_prev      = q_reg[s-1];
            assign r_prev      = r_reg[s-1];
            assign src_prev    = src_reg[s-1];
            assign stride_prev = stride_reg[s-1];
        end

        assign t_next  = {r_prev, q_prev[W-1]};
        assign ge_next = (t_next >= {1'b0, od});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[s]      <= {q_prev[W-2:0], ge_next};
            r_reg[s]      <= ge_next ? SIZE_BITS'(t_next - {1'b0, od})
                                     : SIZE_BITS'(t_next);
            src_reg[s]    <= src_prev;
            stride_reg[s] <= stride_prev;
        end
    end

    // weight the digit and advance the stride
    logic [W-1:0] digit;
    logic [W-1:0] src_next;
    logic [W-1:0] stride_next;
    logic         valid_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] src_o_reg;
    logic [W-1:0] stride_o_reg;

    assign digit       = (id == size_t'(1)) ? '0 : W'(r_reg[W-1]);
    assign src_next    = src_reg[W-1] + W'(digit * stride_reg[W-1]);
    assign stride_next = W'(stride_reg[W-1] * W'(id));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= v_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= q_reg[W-1];
        src_o_reg    <= src_next;
        stride_o_reg <= stride_next;
    end

    assign out_valid  = valid_reg;
    assign out_rem    = rem_reg;
    assign out_src    = src_o_reg;
    assign out_stride = stride_o_reg;

endmodule

// ===== sv/broadcast_expand_index_unit.sv =====
// channel | ports                                   | beat when
// cfg     | cfg_we, cfg_addr, cfg_data              | cfg_we high
// in      | start, busy, dest_index                 | start high, busy low
// out     | done, source_index, out_of_range        | done high, one cycle
// One item per cycle; busy stays low. The pipeline runs RANK dimensions in turn:
// each dimension is an INDEX_BITS-stage bit-per-stage divider plus one
// multiply-accumulate stage, then an output register.
// Reset clears the valid bits and sets all sizes to one.
// The receiver cannot stall, so the pipeline never holds.
module broadcast_expand_index_unit #(
    parameter int RANK       = 4,
    parameter int INDEX_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bei_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [bei_pkg::SIZE_BITS-1:0]     cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [31:0]                       dest_index,
    output logic                              done,
    output logic [31:0]                       source_index,
    output logic                              out_of_range
);
    import bei_pkg::*;

    localparam int W   = INDEX_BITS;
    localparam int LAT = RANK * (W + 1) + 1;

    size_t out_size_reg [0:CFG_SLOTS-1];
    size_t in_size_reg  [0:CFG_SLOTS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CFG_SLOTS; k++)
            begin
                out_size_reg[k] <= size_t'(1);
                in_size_reg[k]  <= size_t'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr < CFG_IN_SIZE_BASE)
            begin
                out_size_reg[cfg_addr[1:0]] <= cfg_data;
            end
            else if (cfg_addr < CFG_END)
            begin
                in_size_reg[cfg_addr[1:0]] <= cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    logic [W-1:0] dest_w;
    if (W >= 32) begin : g_wide
        assign dest_w = W'(dest_index);
    end else begin : g_narrow
        assign dest_w = dest_index[W-1:0];
    end

    // chain index c feeds the dimension RANK-1-c (innermost first)
    logic         v_c      [0:RANK];
    logic [W-1:0] rem_c    [0:RANK];
    logic [W-1:0] src_c    [0:RANK];
    logic [W-1:0] stride_c [0:RANK];

    assign v_c[0]      = start;
    assign rem_c[0]    = dest_w;
    assign src_c[0]    = '0;
    assign stride_c[0] = W'(1);

    for (genvar c = 0; c < RANK; c++) begin : g_dim
        localparam int D = RANK - 1 - c;
        dim_cfg_t dcfg;
        if (D < CFG_SLOTS) begin : g_cfg
            assign dcfg.out_size = out_size_reg[D];
            assign dcfg.in_size  = in_size_reg[D];
        end else begin : g_pad
            assign dcfg.out_size = size_t'(1);
            assign dcfg.in_size  = size_t'(1);
        end

        bei_dim #(.W(W)) u_dim (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (dcfg),
            .in_valid  (v_c[c]),
            .in_rem    (rem_c[c]),
            .in_src    (src_c[c]),
            .in_stride (stride_c[c]),
            .out_valid (v_c[c+1]),
            .out_rem   (rem_c[c+1]),
            .out_src   (src_c[c+1]),
            .out_stride(stride_c[c+1])
        );
    end

    logic        done_reg;
    logic [31:0] source_index_reg;
    logic        out_of_range_reg;
    logic [31:0] src_32;

    if (W >= 32) begin : g_out_wide
        assign src_32 = src_c[RANK][31:0];
    end else begin : g_out_narrow
        assign src_32 = 32'(src_c[RANK]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_c[RANK];
        end
    end

    always_ff @(posedge clk)
    begin
        source_index_reg <= src_32;
        out_of_range_reg <= (rem_c[RANK] != '0);
    end

    assign done         = done_reg;
    assign source_index = source_index_reg;
    assign out_of_range = out_of_range_reg;

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("done without a matching start");

    a_zero_maps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && (dest_index == 32'd0), LAT))
            |-> (source_index == 32'd0 && !out_of_range))
        else $error("index zero did not map to zero");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !busy)
        else $error("busy raised");

endmodule
